FILE: src/c8_pkg.sv
// Shared types, constants and helper functions for the CHIP-8 interpreter core.
// Depends on nothing; the core, the checker and the testbench import it.
`default_nettype none
package c8_pkg;

    localparam int MEM_BYTES         = 4096;
    localparam int ADDR_W            = 12;
    localparam int DISP_W            = 64;
    localparam int DISP_H            = 32;
    localparam int ROW_W             = 5;
    localparam int NUM_REGS          = 16;
    localparam int FONT_BYTES        = 80;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int PROGRAM_START_DEF = 512;

    // Item actions.
    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ROW   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_STACK_FULL  = 2'd1;
    localparam logic [1:0] STAT_STACK_EMPTY = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN     = 2'd3;

    // Whole-word opcodes and sub-codes.
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  KEY_DOWN = 8'h9E;
    localparam logic [7:0]  KEY_UP   = 8'hA1;
    localparam logic [7:0]  F_GET_DELAY = 8'h07;
    localparam logic [7:0]  F_WAIT_KEY  = 8'h0A;
    localparam logic [7:0]  F_SET_DELAY = 8'h15;
    localparam logic [7:0]  F_SET_SOUND = 8'h18;
    localparam logic [7:0]  F_ADD_INDEX = 8'h1E;
    localparam logic [7:0]  F_GLYPH     = 8'h29;
    localparam logic [7:0]  F_BCD       = 8'h33;
    localparam logic [7:0]  F_SAVE      = 8'h55;
    localparam logic [7:0]  F_LOAD      = 8'h65;

    // Built-in hex glyphs, five bytes each.
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y,
        ST_READ_V0, ST_EXEC, ST_SET_VF, ST_CLS, ST_DRAW_RD, ST_DRAW_WR,
        ST_BCD, ST_SAVE_RD, ST_SAVE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_TICK,
        ST_ROW, ST_FINISH
    } state_t;

    // Rotate a 64-bit row right by s places.
    function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] s);
        logic [127:0] t;
        t = {v, v} >> s;
        return t[63:0];
    endfunction

    // Decimal digit k (0 hundreds, 1 tens, 2 ones) of an 8-bit value.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = 7'(v - 8'(h) * 8'd100);
        p = 15'(r) * 15'd205;
        t = 4'(p >> 11);
        o = 7'(r - 7'(t) * 7'd10);
        case (k)
            2'd0:    return {6'd0, h};
            2'd1:    return {4'd0, t};
            default: return {1'b0, o};
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: src/c8_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for main memory, display rows, data registers and the return stack.
`default_nettype none
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, returns old data on a same-address write.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: src/chip8_instruction_core.sv
// CHIP-8 interpreter core: top level with the instruction sequencer.
// Depends on c8_pkg and c8_ram.
//
// After reset the core runs a clearing pass that loads the font, zeroes the
// rest of memory, the display and the data registers; s_ready stays low
// meanwhile. One item is processed at a time, each read of state going through
// a synchronous memory. A memory write is done as the item is taken, a row read
// passes a row-read state. An instruction is fetched, its operands read and it
// is executed; 8XYN ops that set VF add a flag write, DXYN a read and write per
// sprite row plus the flag, FX55/FX65 a read and write per register, FX33 a
// write per digit and 00E0 one per row. The result sits in an output register,
// so the next item is taken while a result still waits for m_ready.
`default_nettype none
module chip8_instruction_core #(
    parameter int STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF,
    parameter int PROGRAM_START = c8_pkg::PROGRAM_START_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [11:0] s_address,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [15:0] s_key_state,
    input  wire logic [7:0]  s_random_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_program_counter,
    output logic             m_draw_flag,
    output logic             m_beep,
    output logic [63:0]      m_display_row,
    output logic [1:0]       m_status
);
    import c8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    state_t state_reg, state_next;
    logic [11:0] clr_reg, clr_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0] delay_reg, delay_next, sound_reg, sound_next;
    logic m_valid_reg, m_valid_next;

    logic [15:0] op_reg, op_next;
    logic [7:0] op_hi_reg, op_hi_next;
    logic [7:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [4:0] cnt_reg, cnt_next;
    logic flag_reg, flag_next;
    logic [15:0] key_reg, key_next;
    logic [7:0] rnd_reg, rnd_next;
    logic res_draw_reg, res_draw_next, res_beep_reg, res_beep_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [63:0] res_row_reg, res_row_next;
    logic [11:0] m_pc_reg, m_pc_next;
    logic m_draw_reg, m_draw_next, m_beep_reg, m_beep_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [63:0] m_row_reg, m_row_next;

    // Memory ports.
    logic mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata, mem_rdata;
    logic disp_we;
    logic [ROW_W-1:0] disp_waddr, disp_raddr;
    logic [63:0] disp_wdata, disp_rdata;
    logic reg_we;
    logic [3:0] reg_waddr, reg_raddr;
    logic [7:0] reg_wdata, reg_rdata;
    logic stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [11:0] stk_wdata, stk_rdata;

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );
    c8_ram #(.WIDTH(DISP_W), .DEPTH(DISP_H)) u_disp_mem (
        .aclk(aclk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
        .raddr(disp_raddr), .rdata(disp_rdata)
    );
    c8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_reg_mem (
        .aclk(aclk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_rdata)
    );
    c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_mem (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Decoded instruction fields and helpers.
    logic [3:0] opc, op_x, op_n;
    logic [7:0] op_nn;
    logic [11:0] op_nnn, pc_step, pc_skip, idx_cnt;
    logic [8:0] add_sum;
    logic [63:0] sprite_mask;
    logic [ROW_W-1:0] draw_row;
    logic [3:0] low_key;
    logic key_down;
    logic [SPW-1:0] sp_dec;

    assign opc     = op_reg[15:12];
    assign op_x    = op_reg[11:8];
    assign op_n    = op_reg[3:0];
    assign op_nn   = op_reg[7:0];
    assign op_nnn  = op_reg[11:0];
    assign pc_step = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;
    assign idx_cnt = idx_reg[11:0] + {7'd0, cnt_reg};
    assign add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign sprite_mask = rotr64({mem_rdata, 56'd0}, vx_reg[5:0]);
    assign draw_row = vy_reg[ROW_W-1:0] + cnt_reg;
    assign key_down = key_reg[vx_reg[3:0]];
    assign sp_dec = sp_reg - SPW'(1);
    assign stk_raddr = sp_dec[SAW-1:0];

    // Lowest pressed key.
    always_comb begin
        low_key = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (key_reg[k]) begin
                low_key = 4'(k);
            end
        end
    end

    // Sequencer: next state, state updates and memory port control.
    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        pc_next = pc_reg;
        idx_next = idx_reg;
        sp_next = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        op_next = op_reg;
        op_hi_next = op_hi_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        cnt_next = cnt_reg;
        flag_next = flag_reg;
        key_next = key_reg;
        rnd_next = rnd_reg;
        res_draw_next = res_draw_reg;
        res_beep_next = res_beep_reg;
        res_status_next = res_status_reg;
        res_row_next = res_row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pc_next = m_pc_reg;
        m_draw_next = m_draw_reg;
        m_beep_next = m_beep_reg;
        m_status_next = m_status_reg;
        m_row_next = m_row_reg;
        mem_we = 1'b0;
        mem_waddr = idx_cnt;
        mem_wdata = 8'd0;
        mem_raddr = pc_reg;
        disp_we = 1'b0;
        disp_waddr = draw_row;
        disp_wdata = 64'd0;
        disp_raddr = draw_row;
        reg_we = 1'b0;
        reg_waddr = op_x;
        reg_wdata = 8'd0;
        reg_raddr = op_x;
        stk_we = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = pc_reg;
        s_ready = 1'b0;

        case (state_reg)
            // Clearing pass: font, zero memory, display and registers.
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg < 12'(FONT_BYTES)) ? FONT[clr_reg[6:0]] : 8'd0;
                disp_we = (clr_reg < 12'(DISP_H));
                disp_waddr = clr_reg[ROW_W-1:0];
                reg_we = (clr_reg < 12'(NUM_REGS));
                reg_waddr = clr_reg[3:0];
                if (clr_reg == 12'(MEM_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 12'd1;
                end
            end
            // Wait for an input transfer.
            ST_IDLE: begin
                s_ready = 1'b1;
                disp_raddr = s_address[ROW_W-1:0];
                if (s_valid) begin
                    key_next = s_key_state;
                    rnd_next = s_random_byte;
                    res_draw_next = 1'b0;
                    res_beep_next = 1'b0;
                    res_status_next = STAT_OK;
                    res_row_next = 64'd0;
                    case (s_action)
                        ACT_EXEC:  state_next = ST_FETCH_HI;
                        ACT_WRITE: begin
                            mem_we = 1'b1;
                            mem_waddr = s_address;
                            mem_wdata = s_write_data;
                            state_next = ST_FINISH;
                        end
                        ACT_ROW:   state_next = ST_ROW;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ROW: begin
                res_row_next = disp_rdata;
                state_next = ST_FINISH;
            end
            // Instruction fetch and operand reads.
            ST_FETCH_HI: begin
                mem_raddr = pc_reg;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                mem_raddr = pc_reg + 12'd1;
                op_hi_next = mem_rdata;
                state_next = ST_READ_X;
            end
            ST_READ_X: begin
                op_next = {op_hi_reg, mem_rdata};
                reg_raddr = op_hi_reg[3:0];
                state_next = ST_READ_Y;
            end
            ST_READ_Y: begin
                vx_next = reg_rdata;
                reg_raddr = op_reg[7:4];
                state_next = ST_READ_V0;
            end
            ST_READ_V0: begin
                vy_next = reg_rdata;
                reg_raddr = 4'd0;
                state_next = ST_EXEC;
            end
            // Execute; reg_rdata holds V0 here.
            ST_EXEC: begin
                state_next = ST_TICK;
                case (opc)
                    4'h0: begin
                        if (op_reg == OP_CLS) begin
                            cnt_next = 5'd0;
                            pc_next = pc_step;
                            state_next = ST_CLS;
                        end else if (op_reg == OP_RET) begin
                            if (sp_reg == '0) begin
                                res_status_next = STAT_STACK_EMPTY;
                            end else begin
                                sp_next = sp_dec;
                                pc_next = stk_rdata + 12'd2;
                            end
                        end else begin
                            pc_next = op_nnn;
                        end
                    end
                    4'h1: pc_next = op_nnn;
                    4'h2: begin
                        if (sp_reg == SPW'(STACK_DEPTH)) begin
                            res_status_next = STAT_STACK_FULL;
                        end else begin
                            stk_we = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                            pc_next = op_nnn;
                        end
                    end
                    4'h3: pc_next = (vx_reg == op_nn) ? pc_skip : pc_step;
                    4'h4: pc_next = (vx_reg != op_nn) ? pc_skip : pc_step;
                    4'h5: pc_next = (vx_reg == vy_reg) ? pc_skip : pc_step;
                    4'h6: begin
                        reg_we = 1'b1;
                        reg_wdata = op_nn;
                        pc_next = pc_step;
                    end
                    4'h7: begin
                        reg_we = 1'b1;
                        reg_wdata = vx_reg + op_nn;
                        pc_next = pc_step;
                    end
                    4'h8: begin
                        reg_we = 1'b1;
                        pc_next = pc_step;
                        case (op_n)
                            4'h0: reg_wdata = vy_reg;
                            4'h1: reg_wdata = vx_reg | vy_reg;
                            4'h2: reg_wdata = vx_reg & vy_reg;
                            4'h3: reg_wdata = vx_reg ^ vy_reg;
                            4'h4: begin
                                reg_wdata = add_sum[7:0];
                                flag_next = add_sum[8];
                                state_next = ST_SET_VF;
                            end
                            4'h5: begin
                                reg_wdata = vx_reg - vy_reg;
                                flag_next = (vx_reg >= vy_reg);
                                state_next = ST_SET_VF;
                            end
                            4'h6: begin
                                reg_wdata = {1'b0, vx_reg[7:1]};
                                flag_next = vx_reg[0];
                                state_next = ST_SET_VF;
                            end
                            4'h7: begin
                                reg_wdata = vy_reg - vx_reg;
                                flag_next = (vy_reg >= vx_reg);
                                state_next = ST_SET_VF;
                            end
                            4'hE: begin
                                reg_wdata = {vx_reg[6:0], 1'b0};
                                flag_next = vx_reg[7];
                                state_next = ST_SET_VF;
                            end
                            default: begin
                                reg_we = 1'b0;
                                pc_next = pc_reg;
                                res_status_next = STAT_UNKNOWN;
                            end
                        endcase
                    end
                    4'h9: pc_next = (vx_reg != vy_reg) ? pc_skip : pc_step;
                    4'hA: begin
                        idx_next = {4'd0, op_nnn};
                        pc_next = pc_step;
                    end
                    4'hB: pc_next = {4'd0, reg_rdata} + op_nnn;
                    4'hC: begin
                        reg_we = 1'b1;
                        reg_wdata = rnd_reg & op_nn;
                        pc_next = pc_step;
                    end
                    4'hD: begin
                        res_draw_next = 1'b1;
                        pc_next = pc_step;
                        cnt_next = 5'd0;
                        flag_next = 1'b0;
                        state_next = (op_n == 4'd0) ? ST_SET_VF : ST_DRAW_RD;
                    end
                    4'hE: begin
                        if (op_nn == KEY_DOWN) begin
                            pc_next = key_down ? pc_skip : pc_step;
                        end else if (op_nn == KEY_UP) begin
                            pc_next = key_down ? pc_step : pc_skip;
                        end else begin
                            res_status_next = STAT_UNKNOWN;
                        end
                    end
                    default: begin
                        pc_next = pc_step;
                        cnt_next = 5'd0;
                        case (op_nn)
                            F_GET_DELAY: begin
                                reg_we = 1'b1;
                                reg_wdata = delay_reg;
                            end
                            F_WAIT_KEY: begin
                                if (key_reg == 16'd0) begin
                                    pc_next = pc_reg;
                                end else begin
                                    reg_we = 1'b1;
                                    reg_wdata = {4'd0, low_key};
                                end
                            end
                            F_SET_DELAY: delay_next = vx_reg;
                            F_SET_SOUND: sound_next = vx_reg;
                            F_ADD_INDEX: idx_next = idx_reg + {8'd0, vx_reg};
                            F_GLYPH: idx_next = {10'd0, vx_reg[3:0], 2'd0}
                                              + {12'd0, vx_reg[3:0]};
                            F_BCD:  state_next = ST_BCD;
                            F_SAVE: state_next = ST_SAVE_RD;
                            F_LOAD: state_next = ST_LOAD_RD;
                            default: begin
                                pc_next = pc_reg;
                                res_status_next = STAT_UNKNOWN;
                            end
                        endcase
                    end
                endcase
            end
            // Flag write lands after the result register write.
            ST_SET_VF: begin
                reg_we = 1'b1;
                reg_waddr = 4'hF;
                reg_wdata = {7'd0, flag_reg};
                state_next = ST_TICK;
            end
            ST_CLS: begin
                disp_we = 1'b1;
                disp_waddr = cnt_reg;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DISP_H - 1)) begin
                    state_next = ST_TICK;
                end
            end
            // Sprite draw: read sprite byte and row, then XOR back.
            ST_DRAW_RD: begin
                mem_raddr = idx_cnt;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                disp_we = 1'b1;
                disp_wdata = disp_rdata ^ sprite_mask;
                flag_next = flag_reg | (|(disp_rdata & sprite_mask));
                cnt_next = cnt_reg + 5'd1;
                state_next = (cnt_reg[3:0] + 4'd1 == op_n) ? ST_SET_VF : ST_DRAW_RD;
            end
            ST_BCD: begin
                mem_we = 1'b1;
                mem_wdata = bcd_digit(vx_reg, cnt_reg[1:0]);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2) begin
                    state_next = ST_TICK;
                end
            end
            ST_SAVE_RD: begin
                reg_raddr = cnt_reg[3:0];
                state_next = ST_SAVE_WR;
            end
            ST_SAVE_WR: begin
                mem_we = 1'b1;
                mem_wdata = reg_rdata;
                cnt_next = cnt_reg + 5'd1;
                state_next = (cnt_reg[3:0] == op_x) ? ST_TICK : ST_SAVE_RD;
            end
            ST_LOAD_RD: begin
                mem_raddr = idx_cnt;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                reg_we = 1'b1;
                reg_waddr = cnt_reg[3:0];
                reg_wdata = mem_rdata;
                cnt_next = cnt_reg + 5'd1;
                state_next = (cnt_reg[3:0] == op_x) ? ST_TICK : ST_LOAD_RD;
            end
            // Timers count down once per executed instruction.
            ST_TICK: begin
                if (delay_reg != 8'd0) begin
                    delay_next = delay_reg - 8'd1;
                end
                if (sound_reg != 8'd0) begin
                    sound_next = sound_reg - 8'd1;
                end
                res_beep_next = (sound_reg == 8'd1);
                state_next = ST_FINISH;
            end
            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pc_next = pc_reg;
                    m_draw_next = res_draw_reg;
                    m_beep_next = res_beep_reg;
                    m_status_next = res_status_reg;
                    m_row_next = res_row_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= 12'd0;
            pc_reg <= 12'(PROGRAM_START);
            idx_reg <= 16'd0;
            sp_reg <= '0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= pc_next;
            idx_reg <= idx_next;
            sp_reg <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        op_hi_reg <= op_hi_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        cnt_reg <= cnt_next;
        flag_reg <= flag_next;
        key_reg <= key_next;
        rnd_reg <= rnd_next;
        res_draw_reg <= res_draw_next;
        res_beep_reg <= res_beep_next;
        res_status_reg <= res_status_next;
        res_row_reg <= res_row_next;
        m_pc_reg <= m_pc_next;
        m_draw_reg <= m_draw_next;
        m_beep_reg <= m_beep_next;
        m_status_reg <= m_status_next;
        m_row_reg <= m_row_next;
    end

    assign m_valid = m_valid_reg;
    assign m_program_counter = m_pc_reg;
    assign m_draw_flag = m_draw_reg;
    assign m_beep = m_beep_reg;
    assign m_status = m_status_reg;
    assign m_display_row = m_row_reg;

endmodule
`default_nettype wire

FILE: src/c8_checker.sv
// Port-level checks for the CHIP-8 interpreter core, bound to the top level.
// Depends on chip8_instruction_core's port list and c8_pkg.
`default_nettype none
module c8_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [11:0] m_program_counter,
    input wire logic        m_draw_flag,
    input wire logic        m_beep,
    input wire logic [63:0] m_display_row,
    input wire logic [1:0]  m_status
);
    import c8_pkg::*;

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // Items are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer accepted back to back");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_program_counter)
            && $stable(m_display_row) && $stable(m_status)))
        else $error("stalled result changed");

    // A row read carries no instruction outcome.
    a_row_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_display_row != 64'd0) |->
            (!m_draw_flag && !m_beep && m_status == STAT_OK))
        else $error("row result mixed with instruction result");

    // A refused or unknown instruction never draws.
    a_status_no_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> !m_draw_flag)
        else $error("draw flag with error status");

endmodule

bind chip8_instruction_core c8_checker u_c8_checker (.*);
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the CHIP-8 interpreter core: loads instructions
// into memory, executes them, reads display rows and checks every result.
// Depends on c8_pkg and the chip8_instruction_core RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import c8_pkg::*;

    localparam int TARGET_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    // Opcode groups by top nibble, and ALU sub-codes of group 8.
    typedef enum logic [3:0] {
        GRP_SYS, GRP_JUMP, GRP_CALL, GRP_SKIP_EQ_NN, GRP_SKIP_NE_NN, GRP_SKIP_EQ_REG,
        GRP_LOAD_NN, GRP_ADD_NN, GRP_ALU, GRP_SKIP_NE_REG, GRP_LOAD_INDEX,
        GRP_JUMP_V0, GRP_RANDOM, GRP_DRAW, GRP_KEY, GRP_MISC
    } op_group_t;

    typedef enum logic [3:0] {
        ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
        ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
        ALU_SHL = 4'hE
    } alu_op_t;

    typedef struct packed {
        logic [11:0] pc;
        logic        draw;
        logic        beep;
        logic [63:0] row;
        logic [1:0]  status;
    } step_result_t;

    // Interpreter state mirror and the queue of results still owed by the core.
    class instr_scoreboard;
        logic [7:0]   mem [MEM_BYTES];
        logic [63:0]  disp [DISP_H];
        logic [7:0]   regs [NUM_REGS];
        logic [15:0]  index;
        logic [11:0]  pc;
        logic [11:0]  calls [STACK_DEPTH_DEF];
        int           depth;
        logic [7:0]   delay_timer;
        logic [7:0]   sound_timer;
        step_result_t owed_q[$];
        int errors, checked, draws, beeps, refusals;

        function void clear_state();
            for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
            for (int i = 0; i < DISP_H; i++) disp[i] = '0;
            for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
            for (int i = 0; i < STACK_DEPTH_DEF; i++) calls[i] = '0;
            index = '0;
            pc = 12'(PROGRAM_START_DEF);
            depth = 0;
            delay_timer = '0;
            sound_timer = '0;
        endfunction

        // Rotate a sprite row right so that its first pixel lands in column s.
        function logic [63:0] place_row(logic [7:0] pixels, logic [5:0] s);
            logic [63:0] m;
            m = {pixels, 56'd0};
            return (s == 0) ? m : ((m >> s) | (m << (7'd64 - s)));
        endfunction

        // One instruction; returns the status and flags a sprite draw.
        function logic [1:0] run_instr(logic [15:0] keys, logic [7:0] rnd, output bit drew);
            logic [15:0] op;
            logic [3:0]  x, y;
            logic [7:0]  nn, vx, vy;
            logic [11:0] nnn, nxt, skp, a;
            logic [8:0]  wide;
            logic [63:0] m;
            logic [4:0]  r;
            logic        hit;
            drew = 0;
            op  = {mem[pc], mem[12'(pc + 12'd1)]};
            x   = op[11:8];
            y   = op[7:4];
            nn  = op[7:0];
            nnn = op[11:0];
            vx  = regs[x];
            vy  = regs[y];
            nxt = pc + 12'd2;
            skp = pc + 12'd4;
            case (op_group_t'(op[15:12]))
                GRP_SYS: begin
                    if (op == OP_CLS) begin
                        for (int i = 0; i < DISP_H; i++) disp[i] = '0;
                        pc = nxt;
                    end else if (op == OP_RET) begin
                        if (depth == 0) return STAT_STACK_EMPTY;
                        depth--;
                        pc = calls[depth] + 12'd2;
                    end else begin
                        pc = nnn;
                    end
                end
                GRP_JUMP: pc = nnn;
                GRP_CALL: begin
                    if (depth >= STACK_DEPTH_DEF) return STAT_STACK_FULL;
                    calls[depth] = pc;
                    depth++;
                    pc = nnn;
                end
                GRP_SKIP_EQ_NN:  pc = (vx == nn) ? skp : nxt;
                GRP_SKIP_NE_NN:  pc = (vx != nn) ? skp : nxt;
                GRP_SKIP_EQ_REG: pc = (vx == vy) ? skp : nxt;
                GRP_LOAD_NN: begin
                    regs[x] = nn;
                    pc = nxt;
                end
                GRP_ADD_NN: begin
                    regs[x] = vx + nn;
                    pc = nxt;
                end
                GRP_ALU: begin
                    case (op[3:0])
                        ALU_MOV: regs[x] = vy;
                        ALU_OR:  regs[x] = vx | vy;
                        ALU_AND: regs[x] = vx & vy;
                        ALU_XOR: regs[x] = vx ^ vy;
                        ALU_ADD: begin
                            wide = {1'b0, vx} + {1'b0, vy};
                            regs[x] = wide[7:0];
                            regs[15] = {7'd0, wide[8]};
                        end
                        ALU_SUB: begin
                            regs[x] = vx - vy;
                            regs[15] = {7'd0, vx >= vy};
                        end
                        ALU_SHR: begin
                            regs[x] = vx >> 1;
                            regs[15] = {7'd0, vx[0]};
                        end
                        ALU_SUBN: begin
                            regs[x] = vy - vx;
                            regs[15] = {7'd0, vy >= vx};
                        end
                        ALU_SHL: begin
                            regs[x] = vx << 1;
                            regs[15] = {7'd0, vx[7]};
                        end
                        default: return STAT_UNKNOWN;
                    endcase
                    pc = nxt;
                end
                GRP_SKIP_NE_REG: pc = (vx != vy) ? skp : nxt;
                GRP_LOAD_INDEX: begin
                    index = {4'd0, nnn};
                    pc = nxt;
                end
                GRP_JUMP_V0: pc = {4'd0, regs[0]} + nnn;
                GRP_RANDOM: begin
                    regs[x] = rnd & nn;
                    pc = nxt;
                end
                GRP_DRAW: begin
                    hit = 0;
                    for (int i = 0; i < op[3:0]; i++) begin
                        a = index[11:0] + 12'(i);
                        m = place_row(mem[a], vx[5:0]);
                        r = vy[4:0] + 5'(i);
                        if ((disp[r] & m) != 0) hit = 1;
                        disp[r] ^= m;
                    end
                    regs[15] = {7'd0, hit};
                    drew = 1;
                    pc = nxt;
                end
                GRP_KEY: begin
                    if (nn == KEY_DOWN) pc = keys[vx[3:0]] ? skp : nxt;
                    else if (nn == KEY_UP) pc = keys[vx[3:0]] ? nxt : skp;
                    else return STAT_UNKNOWN;
                end
                default: begin
                    case (nn)
                        F_GET_DELAY: regs[x] = delay_timer;
                        F_WAIT_KEY: begin
                            if (keys == 0) return STAT_OK;
                            for (int i = 0; i < 16; i++)
                                if (keys[i]) begin
                                    regs[x] = 8'(i);
                                    break;
                                end
                        end
                        F_SET_DELAY: delay_timer = vx;
                        F_SET_SOUND: sound_timer = vx;
                        F_ADD_INDEX: index = index + {8'd0, vx};
                        F_GLYPH:     index = 16'(vx[3:0]) * 16'd5;
                        F_BCD: begin
                            mem[index[11:0]] = vx / 8'd100;
                            mem[12'(index[11:0] + 12'd1)] = (vx / 8'd10) % 8'd10;
                            mem[12'(index[11:0] + 12'd2)] = vx % 8'd10;
                        end
                        F_SAVE:
                            for (int i = 0; i <= x; i++) mem[12'(index[11:0] + 12'(i))] = regs[i];
                        F_LOAD:
                            for (int i = 0; i <= x; i++) regs[i] = mem[12'(index[11:0] + 12'(i))];
                        default: return STAT_UNKNOWN;
                    endcase
                    pc = nxt;
                end
            endcase
            return STAT_OK;
        endfunction

        // An input transfer was accepted: advance the mirror and owe a result.
        function void note_item(logic [1:0] act, logic [11:0] addr, logic [7:0] data,
                                logic [15:0] keys, logic [7:0] rnd);
            step_result_t res;
            bit drew;
            res = '0;
            if (act == ACT_EXEC) begin
                res.status = run_instr(keys, rnd, drew);
                res.draw = drew;
                if (delay_timer != 0) delay_timer--;
                if (sound_timer != 0) begin
                    res.beep = (sound_timer == 1);
                    sound_timer--;
                end
            end else if (act == ACT_WRITE) begin
                mem[addr] = data;
            end else if (act == ACT_ROW) begin
                res.row = disp[addr[4:0]];
            end
            res.pc = pc;
            owed_q.push_back(res);
        endfunction

        // A result transfer arrived: compare it with the oldest owed result.
        function void check_result(step_result_t got);
            step_result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result with nothing outstanding: %p", got);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            draws += got.draw;
            beeps += got.beep;
            if (got.status != STAT_OK) refusals++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d pc %h/%h draw %b/%b beep %b/%b row %h/%h st %0d/%0d",
                             checked, want.pc, got.pc, want.draw, got.draw, want.beep, got.beep,
                             want.row, got.row, want.status, got.status);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [11:0] s_address = '0;
    logic [7:0]  s_write_data = '0;
    logic [15:0] s_key_state = '0;
    logic [7:0]  s_random_byte = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [11:0] m_program_counter;
    logic        m_draw_flag;
    logic        m_beep;
    logic [63:0] m_display_row;
    logic [1:0]  m_status;

    instr_scoreboard sb = new();
    int sent = 0;
    int cycles = 0;

    chip8_instruction_core dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // Run-away guard.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.owed_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function int send_idle_pct();
        return (sent < TARGET_ITEMS / 3) ? 15 : (sent < 2 * TARGET_ITEMS / 3) ? 56 : 0;
    endfunction

    function int recv_idle_pct();
        return (sent < TARGET_ITEMS / 3) ? 56 : (sent < 2 * TARGET_ITEMS / 3) ? 15 : 0;
    endfunction

    // Result side: check at the rising edge, pick ready at the falling edge.
    // One long hold-off in the idle-free phase lets the core back up.
    always begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result({m_program_counter, m_draw_flag, m_beep, m_display_row, m_status});
            @(negedge aclk);
            if (!hold_done && sent >= 5 * TARGET_ITEMS / 6) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct());
            end
        end
    end

    // Offer one item and wait for its transfer; called at a falling edge.
    task automatic send_item(logic [1:0] act, logic [11:0] addr, logic [7:0] data,
                             logic [15:0] keys, logic [7:0] rnd);
        while ($urandom_range(99) < send_idle_pct()) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_address <= addr;
        s_write_data <= data;
        s_key_state <= keys;
        s_random_byte <= rnd;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(act, addr, data, keys, rnd);
        sent++;
        @(negedge aclk);
    endtask

    // Place an instruction at the current program counter and execute it.
    task automatic run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
        logic [11:0] at;
        at = sb.pc;
        send_item(ACT_WRITE, at, op[15:8], 16'($urandom), 8'($urandom));
        send_item(ACT_WRITE, at + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
        send_item(ACT_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    // Random instruction, biased toward operations that do something.
    function automatic logic [15:0] pick_op();
        logic [15:0] op;
        logic [7:0]  fcodes [9];
        fcodes = '{F_GET_DELAY, F_WAIT_KEY, F_SET_DELAY, F_SET_SOUND, F_ADD_INDEX,
                   F_GLYPH, F_BCD, F_SAVE, F_LOAD};
        op = 16'($urandom);
        case (op_group_t'(op[15:12]))
            GRP_SYS:
                case ($urandom_range(3))
                    0: op = OP_CLS;
                    1: op = OP_RET;
                    default: ;
                endcase
            GRP_SKIP_EQ_NN, GRP_SKIP_NE_NN:
                if ($urandom_range(1)) op[7:0] = sb.regs[op[11:8]];
            GRP_LOAD_NN, GRP_ADD_NN:
                if ($urandom_range(2) == 0) op[7:0] = 8'($urandom_range(3));
            GRP_KEY:
                if ($urandom_range(4) != 0) op[7:0] = $urandom_range(1) ? KEY_DOWN : KEY_UP;
            GRP_MISC:
                if ($urandom_range(7) != 0) op[7:0] = fcodes[$urandom_range(8)];
            default: ;
        endcase
        return op;
    endfunction

    task automatic random_keys(output logic [15:0] keys);
        keys = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
    endtask

    initial begin
        logic [15:0] keys;
        int choice;
        sb.clear_state();
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: wrap-around draw, empty sprite, unknown opcode, key wait,
        // row-select truncation and memory extremes.
        send_item(ACT_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(ACT_WRITE, 12'h000, 8'h00, 16'h0000, 8'h00);
        run_op(16'h603F, 16'h0000, 8'h00);
        run_op(16'h611F, 16'hFFFF, 8'hFF);
        run_op(16'hF029, 16'h0000, 8'h00);
        run_op(16'hD015, 16'h0000, 8'h00);
        run_op(16'hD010, 16'h0000, 8'h00);
        run_op(16'h8EFF, 16'h0000, 8'h00);
        run_op(16'hF00A, 16'h0000, 8'h00);
        send_item(ACT_ROW, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_item(ACT_ROW, 12'h000, 8'hFF, 16'hFFFF, 8'hFF);

        // Random instruction stream with memory noise, row reads and deep
        // call chains that overflow and then underflow the return stack.
        while (sent < TARGET_ITEMS) begin
            choice = $urandom_range(99);
            random_keys(keys);
            if (choice < 2) begin
                repeat (STACK_DEPTH_DEF + 1) run_op({4'h2, 12'($urandom)}, keys, 8'($urandom));
                repeat (STACK_DEPTH_DEF + 1) run_op(OP_RET, keys, 8'($urandom));
            end else if (choice < 10) begin
                send_item(ACT_WRITE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            end else if (choice < 20) begin
                send_item(ACT_ROW, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            end else begin
                run_op(pick_op(), keys, 8'($urandom));
            end
        end
        s_valid <= 0;

        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d transfers in, %0d results: %0d draws, %0d beeps, %0d refusals.",
                 sent, sb.checked, sb.draws, sb.beeps, sb.refusals);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
